[rtl/infix_to_postfix_converter_core_macros.svh]
// Assertion macros for the converter's port-level checker file.
`ifndef INFIX_TO_POSTFIX_CONVERTER_CORE_MACROS_SVH
`define INFIX_TO_POSTFIX_CONVERTER_CORE_MACROS_SVH

// Property checked on every clock edge outside reset.
`define ITP_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("itp assertion failed");

// Property checked on every clock edge, reset included.
`define ITP_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("itp assertion failed");

`endif

[rtl/itp_pkg.sv]
// Types, codes and helper functions of the infix-to-postfix converter.
package itp_pkg;

   typedef enum logic [2:0] {
      OP_NONE = 3'd0,
      OP_ADD  = 3'd1,
      OP_SUB  = 3'd2,
      OP_MUL  = 3'd3,
      OP_DIV  = 3'd4,
      OP_POW  = 3'd5,
      OP_LPAR = 3'd6
   } op_code_type;

   typedef enum logic [2:0] {
      CLS_OTHER,
      CLS_LETTER,
      CLS_OP,
      CLS_LPAR,
      CLS_RPAR,
      CLS_END
   } char_class_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_OP,
      S_CLOSE,
      S_FLUSH
   } state_type;

   typedef enum logic [1:0] {
      EMIT_REQ,
      EMIT_TOP,
      EMIT_ZERO
   } emit_sel_type;

   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_OVERFLOW = 2'd1;
   localparam logic [1:0] ERR_PAREN    = 2'd2;

   localparam logic [7:0] CHAR_END   = 8'd0;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_STAR  = 8'h2A;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_CARET = 8'h5E;
   localparam logic [7:0] CHAR_LPAR  = 8'h28;
   localparam logic [7:0] CHAR_RPAR  = 8'h29;
   localparam logic [7:0] CHAR_UC_A  = 8'd65;
   localparam logic [7:0] CHAR_UC_Z  = 8'd90;
   localparam logic [7:0] CHAR_LC_A  = 8'd97;
   localparam logic [7:0] CHAR_LC_Z  = 8'd122;

   typedef struct packed {
      logic         load_cur;
      logic         push;
      logic         push_req;
      logic         pop;
      logic         emit;
      emit_sel_type emit_sel;
      logic [1:0]   emit_error;
      logic         emit_last;
   } dp_cmd_type;

   typedef struct packed {
      logic           out_free;
      logic           stack_empty;
      logic           stack_full;
      op_code_type    top_op;
      op_code_type    cur_op;
      char_class_type req_class;
   } dp_status_type;

   function automatic logic [1:0] op_prec(input op_code_type op);
      logic [1:0] prec;
      case (op)
         OP_ADD, OP_SUB: prec = 2'd1;
         OP_MUL, OP_DIV: prec = 2'd2;
         OP_POW:         prec = 2'd3;
         default:        prec = 2'd0;
      endcase
      return prec;
   endfunction

   function automatic logic [7:0] op_char(input op_code_type op);
      logic [7:0] ch;
      case (op)
         OP_ADD:  ch = CHAR_PLUS;
         OP_SUB:  ch = CHAR_MINUS;
         OP_MUL:  ch = CHAR_STAR;
         OP_DIV:  ch = CHAR_SLASH;
         OP_POW:  ch = CHAR_CARET;
         OP_LPAR: ch = CHAR_LPAR;
         default: ch = CHAR_END;
      endcase
      return ch;
   endfunction

   function automatic op_code_type char_op(input logic [7:0] ch);
      op_code_type op;
      case (ch)
         CHAR_PLUS:  op = OP_ADD;
         CHAR_MINUS: op = OP_SUB;
         CHAR_STAR:  op = OP_MUL;
         CHAR_SLASH: op = OP_DIV;
         CHAR_CARET: op = OP_POW;
         CHAR_LPAR:  op = OP_LPAR;
         default:    op = OP_NONE;
      endcase
      return op;
   endfunction

   function automatic char_class_type char_class(input logic [7:0] ch);
      char_class_type cls;
      if ((ch >= CHAR_UC_A && ch <= CHAR_UC_Z) || (ch >= CHAR_LC_A && ch <= CHAR_LC_Z)) begin
         cls = CLS_LETTER;
      end else if (ch == CHAR_END) begin
         cls = CLS_END;
      end else if (ch == CHAR_RPAR) begin
         cls = CLS_RPAR;
      end else if (ch == CHAR_LPAR) begin
         cls = CLS_LPAR;
      end else if (char_op(ch) != OP_NONE) begin
         cls = CLS_OP;
      end else begin
         cls = CLS_OTHER;
      end
      return cls;
   endfunction

endpackage

[rtl/itp_datapath.sv]
// Operator stack, current operator and result register of the converter.
module itp_datapath #(
   parameter int STACK_DEPTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [7:0]            req_char,
   input  itp_pkg::dp_cmd_type   cmd,
   output itp_pkg::dp_status_type status,
   input  logic                  rsp_stall,
   output logic                  rsp_valid,
   output logic [7:0]            rsp_char,
   output logic                  rsp_last,
   output logic [1:0]            rsp_error
);

   localparam int CNT_W = $clog2(STACK_DEPTH + 1);
   localparam int IDX_W = $clog2(STACK_DEPTH);

   itp_pkg::op_code_type stack_mem [STACK_DEPTH];
   itp_pkg::op_code_type top_ff;
   itp_pkg::op_code_type cur_ff;
   itp_pkg::op_code_type req_op;
   itp_pkg::op_code_type push_op;
   logic [CNT_W-1:0]     count_ff;
   logic [IDX_W-1:0]     pop_addr;
   logic                 rsp_valid_ff;
   logic [7:0]           rsp_char_ff;
   logic                 rsp_last_ff;
   logic [1:0]           rsp_error_ff;
   logic [7:0]           emit_char;

   assign req_op   = itp_pkg::char_op(req_char);
   assign push_op  = cmd.push_req ? req_op : cur_ff;
   assign pop_addr = IDX_W'(count_ff - CNT_W'(2));

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         stack_mem[count_ff[IDX_W-1:0]] <= push_op;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         top_ff <= push_op;
      end else if (cmd.pop && count_ff >= CNT_W'(2)) begin
         top_ff <= stack_mem[pop_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.push) begin
         count_ff <= count_ff + CNT_W'(1);
      end else if (cmd.pop) begin
         count_ff <= count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_cur) begin
         cur_ff <= req_op;
      end
   end

   always_comb begin
      case (cmd.emit_sel)
         itp_pkg::EMIT_REQ: emit_char = req_char;
         itp_pkg::EMIT_TOP: emit_char = itp_pkg::op_char(top_ff);
         default:           emit_char = itp_pkg::CHAR_END;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_char_ff  <= emit_char;
         rsp_last_ff  <= cmd.emit_last;
         rsp_error_ff <= cmd.emit_error;
      end
   end

   assign status.out_free    = !rsp_valid_ff || !rsp_stall;
   assign status.stack_empty = (count_ff == '0);
   assign status.stack_full  = (count_ff == CNT_W'(STACK_DEPTH));
   assign status.top_op      = top_ff;
   assign status.cur_op      = cur_ff;
   assign status.req_class   = itp_pkg::char_class(req_char);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_char  = rsp_char_ff;
   assign rsp_last  = rsp_last_ff;
   assign rsp_error = rsp_error_ff;

endmodule

[rtl/itp_ctrl.sv]
// Sequencing state machine of the converter.
module itp_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  itp_pkg::dp_status_type status,
   output itp_pkg::dp_cmd_type    cmd
);

   itp_pkg::state_type state_ff;
   itp_pkg::state_type state_in;
   logic               flush_err_ff;
   logic               flush_err_in;
   logic               top_is_op;
   logic               top_wins;
   logic [1:0]         top_prec;
   logic [1:0]         cur_prec;

   assign top_prec  = itp_pkg::op_prec(status.top_op);
   assign cur_prec  = itp_pkg::op_prec(status.cur_op);
   assign top_is_op = !status.stack_empty && (top_prec != 2'd0);
   assign top_wins  = top_is_op && ((top_prec > cur_prec) ||
                      (top_prec == cur_prec && status.cur_op != itp_pkg::OP_POW));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= itp_pkg::S_IDLE;
         flush_err_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         flush_err_ff <= flush_err_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      flush_err_in   = flush_err_ff;
      req_stall      = 1'b1;
      cmd            = '0;
      cmd.emit_sel   = itp_pkg::EMIT_ZERO;
      cmd.emit_error = itp_pkg::ERR_NONE;
      case (state_ff)
         itp_pkg::S_IDLE: begin
            req_stall = !status.out_free;
            if (req_valid && status.out_free) begin
               case (status.req_class)
                  itp_pkg::CLS_LETTER: begin
                     cmd.emit     = 1'b1;
                     cmd.emit_sel = itp_pkg::EMIT_REQ;
                  end
                  itp_pkg::CLS_LPAR: begin
                     if (status.stack_full) begin
                        cmd.emit       = 1'b1;
                        cmd.emit_error = itp_pkg::ERR_OVERFLOW;
                     end else begin
                        cmd.push     = 1'b1;
                        cmd.push_req = 1'b1;
                     end
                  end
                  itp_pkg::CLS_OP: begin
                     cmd.load_cur = 1'b1;
                     state_in     = itp_pkg::S_OP;
                  end
                  itp_pkg::CLS_RPAR: begin
                     state_in = itp_pkg::S_CLOSE;
                  end
                  itp_pkg::CLS_END: begin
                     flush_err_in = 1'b0;
                     state_in     = itp_pkg::S_FLUSH;
                  end
                  default: begin
                  end
               endcase
            end
         end
         itp_pkg::S_OP: begin
            if (top_wins) begin
               if (status.out_free) begin
                  cmd.pop      = 1'b1;
                  cmd.emit     = 1'b1;
                  cmd.emit_sel = itp_pkg::EMIT_TOP;
               end
            end else if (status.stack_full) begin
               if (status.out_free) begin
                  cmd.emit       = 1'b1;
                  cmd.emit_error = itp_pkg::ERR_OVERFLOW;
                  state_in       = itp_pkg::S_IDLE;
               end
            end else begin
               cmd.push = 1'b1;
               state_in = itp_pkg::S_IDLE;
            end
         end
         itp_pkg::S_CLOSE: begin
            if (status.stack_empty) begin
               if (status.out_free) begin
                  cmd.emit       = 1'b1;
                  cmd.emit_error = itp_pkg::ERR_PAREN;
                  state_in       = itp_pkg::S_IDLE;
               end
            end else if (status.top_op == itp_pkg::OP_LPAR) begin
               cmd.pop  = 1'b1;
               state_in = itp_pkg::S_IDLE;
            end else if (status.out_free) begin
               cmd.pop      = 1'b1;
               cmd.emit     = 1'b1;
               cmd.emit_sel = itp_pkg::EMIT_TOP;
            end
         end
         itp_pkg::S_FLUSH: begin
            if (status.stack_empty) begin
               if (status.out_free) begin
                  cmd.emit       = 1'b1;
                  cmd.emit_last  = 1'b1;
                  cmd.emit_error = flush_err_ff ? itp_pkg::ERR_PAREN : itp_pkg::ERR_NONE;
                  flush_err_in   = 1'b0;
                  state_in       = itp_pkg::S_IDLE;
               end
            end else if (status.top_op == itp_pkg::OP_LPAR) begin
               cmd.pop      = 1'b1;
               flush_err_in = 1'b1;
            end else if (status.out_free) begin
               cmd.pop      = 1'b1;
               cmd.emit     = 1'b1;
               cmd.emit_sel = itp_pkg::EMIT_TOP;
            end
         end
         default: begin
            state_in = itp_pkg::S_IDLE;
         end
      endcase
   end

endmodule

[rtl/infix_to_postfix_converter_core.sv]
// Top level of the shunting-yard infix-to-postfix converter.
// Takes one character per item and returns postfix characters, ending each expression
// (character 0) with a result that has rsp_last set. A letter is passed straight on and
// '(' is pushed; an operator pops the stacked operators that take precedence over it and
// is then pushed; ')' pops stack entries up to and including the matching '(', or gives
// an error when none matches; the end marker pops every stack entry, then ends the result.
// The operator stack is a single-ported memory popped one entry per cycle while the result
// register can take a result. A stalled result register holds the converter in place until
// it drains. An overflowing push is dropped and reported with error code 1; an unmatched
// parenthesis gives code 2.
module infix_to_postfix_converter_core #(
   parameter int STACK_DEPTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_char,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_char,
   output logic       rsp_last,
   output logic [1:0] rsp_error
);

   itp_pkg::dp_cmd_type    cmd;
   itp_pkg::dp_status_type status;

   itp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   itp_datapath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_char  (req_char),
      .cmd       (cmd),
      .status    (status),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_char  (rsp_char),
      .rsp_last  (rsp_last),
      .rsp_error (rsp_error)
   );

endmodule

[rtl/itp_checker.sv]
// Port-level assertions of the converter and their binding to the top level.
`include "infix_to_postfix_converter_core_macros.svh"

module itp_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [7:0] req_char,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_char,
   input logic       rsp_last,
   input logic [1:0] rsp_error
);

   logic req_letter;

   assign req_letter = (req_char >= 8'd65 && req_char <= 8'd90) ||
                       (req_char >= 8'd97 && req_char <= 8'd122);

   `ITP_ASSERT_ALWAYS(a_reset_clears_rsp, clock, reset |=> !rsp_valid)
   `ITP_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_char))
   `ITP_ASSERT(a_last_is_zero, clock, reset, rsp_valid && rsp_last |-> rsp_char == 8'd0 && rsp_error != 2'd1)
   `ITP_ASSERT(a_error_code, clock, reset, rsp_valid |-> rsp_error != 2'd3)
   `ITP_ASSERT(a_letter_passes, clock, reset, req_valid && !req_stall && req_letter |=> rsp_valid && rsp_char == $past(req_char))

endmodule

bind infix_to_postfix_converter_core itp_checker u_itp_checker (.*);

[tb/sv/postfix_stream_checker.sv]
// Checker that predicts the converter's postfix output and compares every result.
`timescale 1ns / 1ps
module postfix_stream_checker #(
   parameter int STACK_DEPTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_char,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [7:0] rsp_char,
   input  logic       rsp_last,
   input  logic [1:0] rsp_error,
   output int         fail_count,
   output int         expected_left
);

   localparam int REPORT_LIMIT = 200;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
      logic [1:0] error;
   } postfix_sym_type;

   postfix_sym_type      awaited_syms[$];
   itp_pkg::op_code_type pending_ops[STACK_DEPTH];
   int                   ops_held = 0;
   int                   faults = 0;

   function automatic logic [1:0] binding_of(input itp_pkg::op_code_type op);
      logic [1:0] strength;
      case (op)
         itp_pkg::OP_POW:                  strength = 2'd3;
         itp_pkg::OP_MUL, itp_pkg::OP_DIV: strength = 2'd2;
         itp_pkg::OP_ADD, itp_pkg::OP_SUB: strength = 2'd1;
         default:                          strength = 2'd0;
      endcase
      return strength;
   endfunction

   function automatic logic [7:0] symbol_of(input itp_pkg::op_code_type op);
      logic [7:0] sym;
      case (op)
         itp_pkg::OP_ADD: sym = itp_pkg::CHAR_PLUS;
         itp_pkg::OP_SUB: sym = itp_pkg::CHAR_MINUS;
         itp_pkg::OP_MUL: sym = itp_pkg::CHAR_STAR;
         itp_pkg::OP_DIV: sym = itp_pkg::CHAR_SLASH;
         itp_pkg::OP_POW: sym = itp_pkg::CHAR_CARET;
         default:         sym = itp_pkg::CHAR_END;
      endcase
      return sym;
   endfunction

   function automatic void await_sym(input logic [7:0] ch, input logic last,
                                     input logic [1:0] error);
      postfix_sym_type sym;
      sym.ch    = ch;
      sym.last  = last;
      sym.error = error;
      awaited_syms.push_back(sym);
   endfunction

   function automatic void convert_char(input logic [7:0] ch);
      itp_pkg::op_code_type incoming;
      itp_pkg::op_code_type top_op;
      logic [1:0]           strength;
      logic [1:0]           paren_err;
      logic                 stop;
      incoming  = itp_pkg::OP_NONE;
      paren_err = itp_pkg::ERR_NONE;
      stop      = 1'b0;
      if ((ch >= itp_pkg::CHAR_UC_A && ch <= itp_pkg::CHAR_UC_Z) ||
          (ch >= itp_pkg::CHAR_LC_A && ch <= itp_pkg::CHAR_LC_Z)) begin
         await_sym(ch, 1'b0, itp_pkg::ERR_NONE);
      end else if (ch == itp_pkg::CHAR_END) begin
         while (ops_held > 0) begin
            ops_held--;
            if (pending_ops[ops_held] == itp_pkg::OP_LPAR) begin
               paren_err = itp_pkg::ERR_PAREN;
            end else begin
               await_sym(symbol_of(pending_ops[ops_held]), 1'b0, itp_pkg::ERR_NONE);
            end
         end
         await_sym(itp_pkg::CHAR_END, 1'b1, paren_err);
      end else if (ch == itp_pkg::CHAR_RPAR) begin
         while (ops_held > 0 && !stop) begin
            ops_held--;
            if (pending_ops[ops_held] == itp_pkg::OP_LPAR) begin
               stop = 1'b1;
            end else begin
               await_sym(symbol_of(pending_ops[ops_held]), 1'b0, itp_pkg::ERR_NONE);
            end
         end
         if (!stop) begin
            await_sym(itp_pkg::CHAR_END, 1'b0, itp_pkg::ERR_PAREN);
         end
      end else begin
         case (ch)
            itp_pkg::CHAR_PLUS:  incoming = itp_pkg::OP_ADD;
            itp_pkg::CHAR_MINUS: incoming = itp_pkg::OP_SUB;
            itp_pkg::CHAR_STAR:  incoming = itp_pkg::OP_MUL;
            itp_pkg::CHAR_SLASH: incoming = itp_pkg::OP_DIV;
            itp_pkg::CHAR_CARET: incoming = itp_pkg::OP_POW;
            itp_pkg::CHAR_LPAR:  incoming = itp_pkg::OP_LPAR;
            default:             incoming = itp_pkg::OP_NONE;
         endcase
         if (incoming != itp_pkg::OP_NONE) begin
            if (incoming != itp_pkg::OP_LPAR) begin
               strength = binding_of(incoming);
               while (ops_held > 0 && !stop) begin
                  top_op = pending_ops[ops_held - 1];
                  if (top_op != itp_pkg::OP_LPAR && (binding_of(top_op) > strength ||
                      (binding_of(top_op) == strength && incoming != itp_pkg::OP_POW))) begin
                     ops_held--;
                     await_sym(symbol_of(top_op), 1'b0, itp_pkg::ERR_NONE);
                  end else begin
                     stop = 1'b1;
                  end
               end
            end
            if (ops_held >= STACK_DEPTH) begin
               await_sym(itp_pkg::CHAR_END, 1'b0, itp_pkg::ERR_OVERFLOW);
            end else begin
               pending_ops[ops_held] = incoming;
               ops_held++;
            end
         end
      end
   endfunction

   always @(posedge clock) begin
      postfix_sym_type want;
      if (reset) begin
         awaited_syms.delete();
         ops_held = 0;
      end else begin
         if (rsp_valid === 1'b1 && !rsp_stall) begin
            if (awaited_syms.size() == 0) begin
               faults++;
               if (faults <= REPORT_LIMIT) begin
                  $display("%0t: unexpected result, expected none, actual char=%h last=%b error=%0d",
                           $time, rsp_char, rsp_last, rsp_error);
               end
            end else begin
               want = awaited_syms.pop_front();
               if (rsp_char !== want.ch || rsp_last !== want.last ||
                   rsp_error !== want.error) begin
                  faults++;
                  if (faults <= REPORT_LIMIT) begin
                     $display("%0t: expected char=%h last=%b error=%0d, actual char=%h last=%b error=%0d",
                              $time, want.ch, want.last, want.error,
                              rsp_char, rsp_last, rsp_error);
                  end
               end
            end
         end
         if (req_valid === 1'b1 && req_stall === 1'b0) begin
            convert_char(req_char);
         end
      end
      fail_count    <= faults;
      expected_left <= awaited_syms.size();
   end

endmodule

[tb/sv/tb_infix_to_postfix_converter_core.sv]
// Testbench top: feeds infix character streams into the converter and reports the verdict.
`timescale 1ns / 1ps
module tb_infix_to_postfix_converter_core;

   localparam int STACK_DEPTH  = 16;
   localparam int RANDOM_ITEMS = 317;
   localparam int LONG_HOLD    = 160;
   localparam int IDLE_LIMIT   = 4000;
   localparam int SETTLE       = 60;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_char;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [7:0] rsp_char;
   logic       rsp_last;
   logic [1:0] rsp_error;

   int         fail_count;
   int         expected_left;
   int         idle_cycles = 0;
   int         holds_asked = 0;
   int         holds_done = 0;
   int         fed_items = 0;
   logic       steady = 1'b0;
   logic [7:0] phrase[$];

   // A+z*(Z-a)^b^c/d, the neighbors of the letter ranges, stray bytes, end,
   // then a lone close paren and an open paren left at end
   logic [7:0] opening_chars[25] = '{
      itp_pkg::CHAR_UC_A, itp_pkg::CHAR_PLUS, itp_pkg::CHAR_LC_Z, itp_pkg::CHAR_STAR,
      itp_pkg::CHAR_LPAR, itp_pkg::CHAR_UC_Z, itp_pkg::CHAR_MINUS,
      itp_pkg::CHAR_LC_A, itp_pkg::CHAR_RPAR, itp_pkg::CHAR_CARET, 8'h62,
      itp_pkg::CHAR_CARET, 8'h63, itp_pkg::CHAR_SLASH, 8'h64,
      8'h40, 8'h5B, 8'h60, 8'h7B, 8'hFF, 8'h01, itp_pkg::CHAR_END,
      itp_pkg::CHAR_RPAR, itp_pkg::CHAR_LPAR, itp_pkg::CHAR_END
   };

   always #5 clock = ~clock;

   infix_to_postfix_converter_core #(
      .STACK_DEPTH(STACK_DEPTH)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_char (req_char),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_char (rsp_char),
      .rsp_last (rsp_last),
      .rsp_error(rsp_error)
   );

   postfix_stream_checker #(
      .STACK_DEPTH(STACK_DEPTH)
   ) u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_char     (req_char),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_char     (rsp_char),
      .rsp_last     (rsp_last),
      .rsp_error    (rsp_error),
      .fail_count   (fail_count),
      .expected_left(expected_left)
   );

   function automatic int idle_span();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 80) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [7:0] random_letter();
      if ($urandom_range(0, 1) == 0) begin
         return 8'($urandom_range(itp_pkg::CHAR_UC_A, itp_pkg::CHAR_UC_Z));
      end
      return 8'($urandom_range(itp_pkg::CHAR_LC_A, itp_pkg::CHAR_LC_Z));
   endfunction

   function automatic logic [7:0] random_op(input int caret_odds);
      logic [7:0] sym;
      if ($urandom_range(0, 99) < caret_odds) return itp_pkg::CHAR_CARET;
      case ($urandom_range(0, 4))
         0:       sym = itp_pkg::CHAR_PLUS;
         1:       sym = itp_pkg::CHAR_MINUS;
         2:       sym = itp_pkg::CHAR_STAR;
         3:       sym = itp_pkg::CHAR_SLASH;
         default: sym = itp_pkg::CHAR_CARET;
      endcase
      return sym;
   endfunction

   function automatic void compose_well_formed(input int terms, input int nest_limit,
                                               input int open_odds, input int caret_odds);
      int placed;
      int open;
      placed = 0;
      open   = 0;
      phrase.delete();
      do begin
         while (open < nest_limit && $urandom_range(0, 99) < open_odds) begin
            phrase.push_back(itp_pkg::CHAR_LPAR);
            open++;
         end
         phrase.push_back(random_letter());
         placed++;
         while (open > 0 && $urandom_range(0, 2) == 0) begin
            phrase.push_back(itp_pkg::CHAR_RPAR);
            open--;
         end
         if (placed < terms) phrase.push_back(random_op(caret_odds));
      end while (placed < terms);
      while (open > 0) begin
         phrase.push_back(itp_pkg::CHAR_RPAR);
         open--;
      end
      phrase.push_back(itp_pkg::CHAR_END);
   endfunction

   function automatic void compose_scramble(input int len, input logic raw);
      int r;
      phrase.delete();
      repeat (len) begin
         r = raw ? 9 : $urandom_range(0, 9);
         if (r < 4) phrase.push_back(random_letter());
         else if (r < 7) phrase.push_back(random_op(0));
         else if (r == 7) phrase.push_back(itp_pkg::CHAR_LPAR);
         else if (r == 8) phrase.push_back(itp_pkg::CHAR_RPAR);
         else phrase.push_back(8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 4) != 0) phrase.push_back(itp_pkg::CHAR_END);
   endfunction

   task automatic send_char(input logic [7:0] ch);
      int gap;
      gap = steady ? 0 : idle_span();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_char  <= ch;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
   endtask

   task automatic feed_phrase();
      foreach (phrase[i]) send_char(phrase[i]);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_left != 0) @(posedge clock);
   endtask

   // receiver: random stall runs, quiet stretches, and a long hold when asked
   initial begin
      logic level;
      int   level_len;
      rsp_stall = 1'b0;
      forever begin
         if (holds_done != holds_asked) begin
            level     = 1'b1;
            level_len = LONG_HOLD;
            holds_done = holds_done + 1;
         end else if ($urandom_range(0, 11) == 0) begin
            level     = 1'b0;
            level_len = $urandom_range(40, 120);
         end else if ($urandom_range(0, 2) == 0) begin
            level     = 1'b1;
            level_len = 1 + idle_span();
         end else begin
            level     = 1'b0;
            level_len = $urandom_range(1, 6);
         end
         rsp_stall <= level;
         repeat (level_len) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid === 1'b1 && req_stall === 1'b0) ||
          (rsp_valid === 1'b1 && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("infix_to_postfix_converter_core verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int pick;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_char  = itp_pkg::CHAR_END;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (opening_chars[i]) send_char(opening_chars[i]);
      drain();

      // hold the receiver off and push a caret chain past the stack depth
      holds_asked = holds_asked + 1;
      while (holds_done != holds_asked) @(posedge clock);
      steady = 1'b1;
      compose_well_formed(STACK_DEPTH + 3, 0, 0, 100);
      feed_phrase();
      steady = 1'b0;
      drain();

      while (fed_items < RANDOM_ITEMS) begin
         pick   = $urandom_range(0, 99);
         steady = ($urandom_range(0, 4) == 0);
         if (pick < 50) begin
            compose_well_formed($urandom_range(1, 6), 4, 20, 20);
         end else if (pick < 62) begin
            compose_well_formed($urandom_range(6, 24), $urandom_range(8, 20), 70, 60);
         end else if (pick < 85) begin
            compose_scramble($urandom_range(2, 12), 1'b0);
         end else begin
            compose_scramble($urandom_range(2, 10), 1'b1);
         end
         fed_items = fed_items + phrase.size();
         feed_phrase();
         if ($urandom_range(0, 14) == 0) drain();
      end
      steady = 1'b0;
      drain();
      repeat (SETTLE) @(posedge clock);

      if (fail_count == 0 && expected_left == 0) begin
         $display("infix_to_postfix_converter_core verification clean");
      end else begin
         $display("infix_to_postfix_converter_core verification failed");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+rtl
rtl/itp_pkg.sv
rtl/itp_datapath.sv
rtl/itp_ctrl.sv
rtl/infix_to_postfix_converter_core.sv
rtl/itp_checker.sv
tb/sv/postfix_stream_checker.sv
tb/sv/tb_infix_to_postfix_converter_core.sv
